FILE: src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker modules.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion sampled on the rising clock edge, masked while reset is high.
`define ASSERT_CLKD(label, ck, rs, prop, msg) \
  label: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Assertion sampled on the rising clock edge, also checked during reset.
`define ASSERT_ALWAYS(label, ck, prop, msg) \
  label: assert property (@(posedge ck) prop) else $error(msg);

`endif

FILE: src/pmsd_pkg.sv
// ----------------------------------------------------------------------------
// pmsd_pkg
// Types and constants shared by the pilot median state detector.
// ----------------------------------------------------------------------------
package pmsd_pkg;

  localparam int SAMPLE_W      = 12;
  localparam int TICK_W        = 16;
  localparam int DEC_W         = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;
  localparam int STATE_W       = 3;
  localparam int WINDOW_SIZE_D = 5;

  // Register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] REG_SPU   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEC   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_A_THR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_B_CTR = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C_CTR = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_E_CTR = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TOL   = 3'd6;

  // Register reset values
  localparam logic [TICK_W-1:0]   SPU_RST   = 16'd1;
  localparam logic [DEC_W-1:0]    DEC_RST   = 8'd1;
  localparam logic [SAMPLE_W-1:0] A_THR_RST = 12'd4000;
  localparam logic [SAMPLE_W-1:0] B_CTR_RST = 12'd3650;
  localparam logic [SAMPLE_W-1:0] C_CTR_RST = 12'd3200;
  localparam logic [SAMPLE_W-1:0] E_CTR_RST = 12'd755;
  localparam logic [SAMPLE_W-1:0] TOL_RST   = 12'd150;

  typedef enum logic [STATE_W-1:0] {
    PS_UNKNOWN = 3'd0,
    PS_A       = 3'd1,
    PS_B       = 3'd2,
    PS_C       = 3'd3,
    PS_E       = 3'd4,
    PS_NONE    = 3'd7
  } pilot_state_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_LOAD,
    ST_RANK,
    ST_SEL,
    ST_PUT
  } fsm_state_t;

  // Control for the row of window cells
  typedef struct packed {
    logic shift;  // push a new sample into the row
    logic load;   // copy own sample to the moving token, clear rank
    logic step;   // compare and rotate the moving tokens one cell
  } cell_ctrl_t;

endpackage

FILE: src/pmsd_cell.sv
// ----------------------------------------------------------------------------
// pmsd_cell
// One window cell: holds a sample and ranks it against the rotating tokens.
// ----------------------------------------------------------------------------
module pmsd_cell #(
  parameter int WINDOW_SIZE = pmsd_pkg::WINDOW_SIZE_D,
  parameter int IDX         = 0,
  localparam int IW         = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1
) (
  input  logic                          clk,
  input  pmsd_pkg::cell_ctrl_t          ctrl,
  input  logic [pmsd_pkg::SAMPLE_W-1:0] shift_in,
  input  logic [pmsd_pkg::SAMPLE_W-1:0] move_in_val,
  input  logic [IW-1:0]                 move_in_idx,
  output logic [pmsd_pkg::SAMPLE_W-1:0] own,
  output logic [pmsd_pkg::SAMPLE_W-1:0] move_val,
  output logic [IW-1:0]                 move_idx,
  output logic [IW-1:0]                 rank
);
  import pmsd_pkg::*;

  logic hit;

  // Token sorts below own sample: smaller, or equal and from a lower cell
  assign hit = (move_val < own) || ((move_val == own) && (move_idx < IW'(IDX)));

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      own <= shift_in;
    end
    if (ctrl.load) begin
      move_val <= own;
      move_idx <= IW'(IDX);
      rank     <= '0;
    end else if (ctrl.step) begin
      rank     <= rank + IW'(hit);
      move_val <= move_in_val;
      move_idx <= move_in_idx;
    end
  end

endmodule

FILE: src/pmsd_window.sv
// ----------------------------------------------------------------------------
// pmsd_window
// Row of sample cells in a ring; captures the cell whose rank is the middle.
// ----------------------------------------------------------------------------
module pmsd_window #(
  parameter int WINDOW_SIZE = pmsd_pkg::WINDOW_SIZE_D,
  localparam int IW         = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1
) (
  input  logic                          clk,
  input  pmsd_pkg::cell_ctrl_t          ctrl,
  input  logic                          capture,
  input  logic [pmsd_pkg::SAMPLE_W-1:0] sample_in,
  output logic [pmsd_pkg::SAMPLE_W-1:0] median
);
  import pmsd_pkg::*;

  logic [SAMPLE_W-1:0] own      [WINDOW_SIZE];
  logic [SAMPLE_W-1:0] move_val [WINDOW_SIZE];
  logic [IW-1:0]       move_idx [WINDOW_SIZE];
  logic [IW-1:0]       rank     [WINDOW_SIZE];
  logic [SAMPLE_W-1:0] pick;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    localparam int PREV = (i + WINDOW_SIZE - 1) % WINDOW_SIZE;
    pmsd_cell #(
      .WINDOW_SIZE (WINDOW_SIZE),
      .IDX         (i)
    ) u_cell (
      .clk         (clk),
      .ctrl        (ctrl),
      .shift_in    ((i == 0) ? sample_in : own[PREV]),
      .move_in_val (move_val[PREV]),
      .move_in_idx (move_idx[PREV]),
      .own         (own[i]),
      .move_val    (move_val[i]),
      .move_idx    (move_idx[i]),
      .rank        (rank[i])
    );
  end

  // Ranks are distinct, so exactly one cell matches
  always_comb begin
    pick = '0;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (rank[i] == IW'(WINDOW_SIZE / 2)) begin
        pick = pick | own[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      median <= pick;
    end
  end

endmodule

FILE: src/pilot_median_state_detector.sv
// ----------------------------------------------------------------------------
// pilot_median_state_detector
// Median filter and state classifier for a charging control pilot signal.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one tick per transaction: ADC sample in tdata, ok flag in
//   tuser. m_axis returns a result transaction (median, pilot state, changed
//   flag) on those ticks that close an update period with a full window.
//   cfg carries register writes (index, data); write only while idle.
// Sequence:
//   A tick that emits nothing leaves the block idle and ready for the next
//   tick. A tick that emits passes through the load, rank, select and put
//   states before the next tick is taken: the rank pass rotates every sample
//   once around the cell ring. Its result shows on m_axis from the output
//   register. A write to decimate_factor starts a bit-serial remainder pass
//   (one tick-count bit per cycle) during which no tick is taken.
// Reset:
//   rst clears counters, loads register defaults and marks no state emitted
//   yet, so the first result always flags a change. Both ready outputs stay
//   low while rst is high. Window contents stay undefined until WINDOW_SIZE
//   samples have been stored.
// Stall:
//   A result waits in the output register; ticks keep flowing while it
//   waits, until another emitting tick finds it still occupied.
// ----------------------------------------------------------------------------
module pilot_median_state_detector #(
  parameter int WINDOW_SIZE = pmsd_pkg::WINDOW_SIZE_D
) (
  input  logic                            clk,
  input  logic                            rst,
  // slave stream
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [15:0]                     s_axis_tdata,  // [11:0] adc_sample, [15:12] zero
  input  logic                            s_axis_tuser,  // [0] adc_ok
  // master stream
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [15:0]                     m_axis_tdata,  // [11:0] median_value,
                                                         // [14:12] pilot_state, [15] zero
  output logic                            m_axis_tuser,  // [0] state_changed
  // configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pmsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmsd_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pmsd_pkg::*;

  localparam int FW = $clog2(WINDOW_SIZE + 1);

  // Configuration registers
  logic [TICK_W-1:0]   spu;
  logic [DEC_W-1:0]    dec;
  logic [SAMPLE_W-1:0] a_thr;
  logic [SAMPLE_W-1:0] b_ctr;
  logic [SAMPLE_W-1:0] c_ctr;
  logic [SAMPLE_W-1:0] e_ctr;
  logic [SAMPLE_W-1:0] tol;

  // Control state
  fsm_state_t          state, state_next;
  logic [TICK_W-1:0]   tick_count;
  logic [DEC_W-1:0]    dec_count;   // tick_count modulo the decimation factor
  logic [FW-1:0]       fill_count;
  logic [3:0]          step_cnt;
  logic [DEC_W-1:0]    rem;
  pilot_state_t        last_state;

  // Output register
  logic [SAMPLE_W-1:0] out_value;
  pilot_state_t        out_state;
  logic                out_changed;

  // Datapath helpers
  logic                cfg_fire, dec_write;
  logic                in_fire, dec_tick, tick_drop, store, wrap, full_after, emit;
  logic [TICK_W-1:0]   spu_eff;
  logic [DEC_W-1:0]    dec_eff;
  logic [TICK_W-1:0]   tick_inc;
  logic [DEC_W:0]      dec_inc;
  logic [DEC_W:0]      rem_try;
  logic [DEC_W-1:0]    rem_next;
  logic                put, capture;
  cell_ctrl_t          cell_ctrl;
  logic [SAMPLE_W-1:0] median;
  logic [SAMPLE_W-1:0] d_b, d_c, d_e;
  pilot_state_t        cls;

  assign cfg_ready = !rst;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign dec_write = cfg_fire && (cfg_index == REG_DEC);

  assign spu_eff = (spu == '0) ? TICK_W'(1) : spu;
  assign dec_eff = (dec == '0) ? DEC_W'(1) : dec;

  assign s_axis_tready = (state == ST_IDLE) && !rst;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Tick decode: store on decimation ticks, drop a decimation tick with a bad sample
  assign dec_tick   = (dec_count == '0);
  assign tick_drop  = dec_tick && !s_axis_tuser;
  assign store      = dec_tick && s_axis_tuser;
  assign tick_inc   = tick_count + TICK_W'(1);
  assign wrap       = (tick_inc >= spu_eff) || (tick_inc == '0);
  assign full_after = (fill_count == FW'(WINDOW_SIZE)) ||
                      (store && (fill_count == FW'(WINDOW_SIZE - 1)));
  assign emit       = in_fire && !tick_drop && wrap && full_after;
  assign dec_inc    = {1'b0, dec_count} + (DEC_W + 1)'(1);

  // One restoring step of tick_count modulo dec_eff, MSB first
  assign rem_try  = {rem, tick_count[4'd15 - step_cnt]};
  assign rem_next = (rem_try >= {1'b0, dec_eff}) ? DEC_W'(rem_try - {1'b0, dec_eff})
                                                 : rem_try[DEC_W-1:0];

  // Classify the captured median; A first, then B, C, E
  assign d_b = (median >= b_ctr) ? (median - b_ctr) : (b_ctr - median);
  assign d_c = (median >= c_ctr) ? (median - c_ctr) : (c_ctr - median);
  assign d_e = (median >= e_ctr) ? (median - e_ctr) : (e_ctr - median);

  always_comb begin
    if (median > a_thr) begin
      cls = PS_A;
    end else if (d_b < tol) begin
      cls = PS_B;
    end else if (d_c < tol) begin
      cls = PS_C;
    end else if (d_e < tol) begin
      cls = PS_E;
    end else begin
      cls = PS_UNKNOWN;
    end
  end

  // Next state and sequencer outputs
  always_comb begin
    state_next      = state;
    cell_ctrl.shift = 1'b0;
    cell_ctrl.load  = 1'b0;
    cell_ctrl.step  = 1'b0;
    capture         = 1'b0;
    put             = 1'b0;
    case (state)
      ST_IDLE: begin
        cell_ctrl.shift = in_fire && store;
        if (emit) begin
          state_next = ST_LOAD;
        end
      end
      ST_MOD: begin
        if (step_cnt == 4'd15) begin
          state_next = ST_IDLE;
        end
      end
      ST_LOAD: begin
        cell_ctrl.load = 1'b1;
        state_next     = ST_RANK;
      end
      ST_RANK: begin
        cell_ctrl.step = 1'b1;
        if (step_cnt == 4'(WINDOW_SIZE - 1)) begin
          state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        capture    = 1'b1;
        state_next = ST_PUT;
      end
      ST_PUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          put        = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // A decimation factor write restarts the remainder pass
    if (dec_write) begin
      state_next = ST_MOD;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      spu   <= SPU_RST;
      dec   <= DEC_RST;
      a_thr <= A_THR_RST;
      b_ctr <= B_CTR_RST;
      c_ctr <= C_CTR_RST;
      e_ctr <= E_CTR_RST;
      tol   <= TOL_RST;
    end else if (cfg_fire) begin
      case (cfg_index)
        REG_SPU:   spu   <= cfg_data;
        REG_DEC:   dec   <= cfg_data[DEC_W-1:0];
        REG_A_THR: a_thr <= cfg_data[SAMPLE_W-1:0];
        REG_B_CTR: b_ctr <= cfg_data[SAMPLE_W-1:0];
        REG_C_CTR: c_ctr <= cfg_data[SAMPLE_W-1:0];
        REG_E_CTR: e_ctr <= cfg_data[SAMPLE_W-1:0];
        REG_TOL:   tol   <= cfg_data[SAMPLE_W-1:0];
        default:   ;
      endcase
    end
  end

  // Tick and decimation counters, fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
      dec_count  <= '0;
      fill_count <= '0;
      rem        <= '0;
    end else begin
      if (in_fire && !tick_drop) begin
        if (wrap) begin
          tick_count <= '0;
          dec_count  <= '0;
        end else begin
          tick_count <= tick_inc;
          dec_count  <= (dec_inc == {1'b0, dec_eff}) ? '0 : dec_inc[DEC_W-1:0];
        end
        if (store && (fill_count != FW'(WINDOW_SIZE))) begin
          fill_count <= fill_count + FW'(1);
        end
      end
      if (dec_write) begin
        rem <= '0;
      end else if (state == ST_MOD) begin
        rem <= rem_next;
        if (step_cnt == 4'd15) begin
          dec_count <= rem_next;
        end
      end
    end
  end

  // Shared step counter: remainder bits or rank rotations
  always_ff @(posedge clk) begin
    if (rst || dec_write || (state == ST_LOAD)) begin
      step_cnt <= '0;
    end else if ((state == ST_MOD) || (state == ST_RANK)) begin
      step_cnt <= step_cnt + 4'd1;
    end
  end

  // Output register and last emitted state
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      last_state    <= PS_NONE;
    end else if (put) begin
      m_axis_tvalid <= 1'b1;
      last_state    <= cls;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (put) begin
      out_value   <= median;
      out_state   <= cls;
      out_changed <= (cls != last_state);
    end
  end

  assign m_axis_tdata = {1'b0, out_state, out_value};
  assign m_axis_tuser = out_changed;

  pmsd_window #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_window (
    .clk       (clk),
    .ctrl      (cell_ctrl),
    .capture   (capture),
    .sample_in (s_axis_tdata[SAMPLE_W-1:0]),
    .median    (median)
  );

endmodule

FILE: src/pmsd_checker.sv
// ----------------------------------------------------------------------------
// pmsd_checker
// Port-level checks of the pilot median state detector, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pmsd_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        m_axis_tuser
);
  import pmsd_pkg::*;

  logic [STATE_W-1:0] seen_state;
  logic [STATE_W-1:0] got_state;
  logic               out_fire;
  logic               stalled;
  logic               flag_want;

  assign out_fire  = m_axis_tvalid && m_axis_tready;
  assign stalled   = m_axis_tvalid && !m_axis_tready;
  assign got_state = m_axis_tdata[14:12];
  assign flag_want = (got_state != seen_state);

  // Track the last pilot state delivered on the master stream
  always_ff @(posedge clk) begin
    if (rst) begin
      seen_state <= PS_NONE;
    end else if (out_fire) begin
      seen_state <= got_state;
    end
  end

  `ASSERT_ALWAYS(a_idle_after_reset, clk, rst |=> !m_axis_tvalid, "result valid after reset")
  `ASSERT_CLKD(a_hold_valid, clk, rst, stalled |=> m_axis_tvalid, "result dropped while stalled")
  `ASSERT_CLKD(a_state_range, clk, rst, m_axis_tvalid |-> (got_state <= PS_E), "state out of range")
  `ASSERT_CLKD(a_changed_flag, clk, rst, out_fire |-> (m_axis_tuser == flag_want), "bad changed flag")

endmodule

bind pilot_median_state_detector pmsd_checker u_pmsd_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the pilot median state detector. A short directed
// stimulus table opens the run. Randomized phases follow, each with a fresh
// register set. Each result is checked field by field against a hand-written
// result or a bench model of the median window and the state classifier.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import pmsd_pkg::*;

  localparam int WIN          = WINDOW_SIZE_D;
  localparam int NUM_REGS     = int'(REG_TOL) + 1;
  // Covers an emitting tick and the remainder pass started by a
  // decimate_factor write.
  localparam int HOLD_CYCLES  = 32;
  localparam int MAX_CYCLES   = 600000;
  localparam int RANDOM_TICKS = 1900;
  localparam int MAX_REPORTS  = 40;

  typedef struct {
    logic [SAMPLE_W-1:0] value;
    pilot_state_t        state;
    bit                  changed;
  } pilot_result_t;

  // One row of the directed part: either a register write or a tick, with
  // an optional hand-written result for rows that are obvious at a glance.
  typedef struct {
    bit                    is_write;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    logic [SAMPLE_W-1:0]   sample;
    bit                    ok;
    bit                    typed;
    pilot_result_t         want;
  } stim_row_t;

  // --------------------------------------------------------------------------
  // DUT signals, all inputs known from time zero
  // --------------------------------------------------------------------------
  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [15:0]           s_axis_tdata  = '0;   // [11:0] adc_sample, [15:12] zero
  logic                  s_axis_tuser  = 1'b0; // [0] adc_ok
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [15:0]           m_axis_tdata;         // [11:0] median_value,
                                               // [14:12] pilot_state, [15] zero
  logic                  m_axis_tuser;         // [0] state_changed
  logic                  cfg_valid     = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index     = '0;
  logic [CFG_DATA_W-1:0] cfg_data      = '0;

  pilot_median_state_detector i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always #6 clk = ~clk;

  // --------------------------------------------------------------------------
  // Bench copy of the detector: registers and state, reset values applied once
  // --------------------------------------------------------------------------
  logic [TICK_W-1:0]   spu_reg   = SPU_RST;
  logic [DEC_W-1:0]    dec_reg   = DEC_RST;
  logic [SAMPLE_W-1:0] a_thr_reg = A_THR_RST;
  logic [SAMPLE_W-1:0] b_ctr_reg = B_CTR_RST;
  logic [SAMPLE_W-1:0] c_ctr_reg = C_CTR_RST;
  logic [SAMPLE_W-1:0] e_ctr_reg = E_CTR_RST;
  logic [SAMPLE_W-1:0] tol_reg   = TOL_RST;

  logic [TICK_W-1:0]   tick_count_m = '0;
  logic [SAMPLE_W-1:0] window_m [WIN];  // left unknown until written
  int                  wr_pos_m     = 0;
  int                  fill_m       = 0;
  pilot_state_t        last_emitted = PS_NONE;

  pilot_result_t       pending_results [$];
  stim_row_t           directed_plan [$];

  int  errors        = 0;
  int  ticks_sent    = 0;
  int  results_seen  = 0;
  int  writes_done   = 0;
  int  cycle_count   = 0;
  bit  send_steady   = 1'b0;  // no gaps between ticks
  bit  sink_steady   = 1'b0;  // no stalls on the result side
  int  level         = 2000;  // slowly moving pilot level for random samples

  function automatic logic [SAMPLE_W-1:0] window_median();
    logic [SAMPLE_W-1:0] s [WIN];
    logic [SAMPLE_W-1:0] v;
    int                  j;
    for (int i = 0; i < WIN; i++) s[i] = window_m[i];
    // insertion sort, then take the middle entry
    for (int i = 1; i < WIN; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    return s[WIN/2];
  endfunction

  function automatic bit near_centre(logic [SAMPLE_W-1:0] v, logic [SAMPLE_W-1:0] c);
    int d;
    d = (v >= c) ? int'(v) - int'(c) : int'(c) - int'(v);
    return d < int'(tol_reg);
  endfunction

  function automatic pilot_state_t classify_level(logic [SAMPLE_W-1:0] v);
    if (v > a_thr_reg)           return PS_A;
    if (near_centre(v, b_ctr_reg)) return PS_B;
    if (near_centre(v, c_ctr_reg)) return PS_C;
    if (near_centre(v, e_ctr_reg)) return PS_E;
    return PS_UNKNOWN;
  endfunction

  // Advance the bench copy by one accepted tick; returns 1 when a result is due.
  function automatic bit detect_tick(input logic [SAMPLE_W-1:0] sample, input bit ok,
                                     output pilot_result_t res);
    int                dec;
    int                spu;
    logic [TICK_W-1:0] next;
    pilot_state_t      st;
    dec = (dec_reg == 0) ? 1 : int'(dec_reg);
    spu = (spu_reg == 0) ? 1 : int'(spu_reg);
    res = '{value: '0, state: PS_UNKNOWN, changed: 1'b0};
    if (int'(tick_count_m) % dec == 0) begin
      // a bad conversion on a storing tick drops the whole tick
      if (!ok) return 1'b0;
      if (wr_pos_m >= WIN) wr_pos_m = 0;
      window_m[wr_pos_m] = sample;
      wr_pos_m = (wr_pos_m + 1) % WIN;
      if (fill_m < WIN) fill_m++;
    end
    next = tick_count_m + 1'b1;
    if (int'(next) < spu && next != 0) begin
      tick_count_m = next;
      return 1'b0;
    end
    tick_count_m = '0;
    if (fill_m < WIN) return 1'b0;
    res.value   = window_median();
    st          = classify_level(res.value);
    res.state   = st;
    res.changed = (st != last_emitted);
    last_emitted = st;
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Directed plan builders
  // --------------------------------------------------------------------------
  function automatic void plan_tick(logic [SAMPLE_W-1:0] sample, bit ok);
    stim_row_t row;
    row = '{is_write: 1'b0, index: '0, data: '0, sample: sample, ok: ok, typed: 1'b0,
            want: '{value: '0, state: PS_UNKNOWN, changed: 1'b0}};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_result(logic [SAMPLE_W-1:0] sample, logic [SAMPLE_W-1:0] value,
                                      pilot_state_t state, bit changed);
    stim_row_t row;
    row = '{is_write: 1'b0, index: '0, data: '0, sample: sample, ok: 1'b1, typed: 1'b1,
            want: '{value: value, state: state, changed: changed}};
    directed_plan.push_back(row);
  endfunction

  function automatic void plan_write(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    stim_row_t row;
    row = '{is_write: 1'b1, index: index, data: data, sample: '0, ok: 1'b0, typed: 1'b0,
            want: '{value: '0, state: PS_UNKNOWN, changed: 1'b0}};
    directed_plan.push_back(row);
  endfunction

  // --------------------------------------------------------------------------
  // Random sample source: a level that dwells near a centre, the A threshold,
  // a rail or anywhere, with small jitter and an occasional wild outlier.
  // --------------------------------------------------------------------------
  function automatic int around(logic [SAMPLE_W-1:0] centre);
    int span;
    span = int'(tol_reg) + 2;
    if (span > 600) span = 600;
    return int'(centre) + int'($urandom_range(0, 2 * span)) - span;
  endfunction

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 6))
        0:       level = int'(a_thr_reg) + int'($urandom_range(0, 6)) - 3;
        1:       level = around(b_ctr_reg);
        2:       level = around(c_ctr_reg);
        3:       level = around(e_ctr_reg);
        4:       level = $urandom_range(0, 1) ? 0 : 4095;
        default: level = int'($urandom_range(0, 4095));
      endcase
    end
    if ($urandom_range(0, 7) == 0) v = int'($urandom_range(0, 4095));
    else                           v = level + int'($urandom_range(0, 6)) - 3;
    if (v < 0)    v = 0;
    if (v > 4095) v = 4095;
    return v[SAMPLE_W-1:0];
  endfunction

  // --------------------------------------------------------------------------
  // Stream and register drivers
  // --------------------------------------------------------------------------
  // Present one tick after a random gap; predict on acceptance.
  task automatic send_tick(stim_row_t row);
    int            gap;
    bit            emitted;
    pilot_result_t pred;
    gap = send_steady ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, row.sample};
    s_axis_tuser  <= row.ok;
    do @(posedge clk); while (!s_axis_tready);
    ticks_sent++;
    emitted = detect_tick(row.sample, row.ok, pred);
    if (row.typed)    pending_results.push_back(row.want);
    else if (emitted) pending_results.push_back(pred);
  endtask

  // One register write transaction; mirror it into the bench copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    writes_done++;
    case (index)
      REG_SPU:   spu_reg   = data;
      REG_DEC:   dec_reg   = data[DEC_W-1:0];
      REG_A_THR: a_thr_reg = data[SAMPLE_W-1:0];
      REG_B_CTR: b_ctr_reg = data[SAMPLE_W-1:0];
      REG_C_CTR: c_ctr_reg = data[SAMPLE_W-1:0];
      REG_E_CTR: e_ctr_reg = data[SAMPLE_W-1:0];
      REG_TOL:   tol_reg   = data[SAMPLE_W-1:0];
      default: begin
        // unused index: no register changes
      end
    endcase
  endtask

  // Drop tvalid, drain all expected results, then let the last silent tick finish.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic note_mismatch(string field, int want, int got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls, compare each transaction with the oldest
  // expectation.
  // --------------------------------------------------------------------------
  initial begin
    int            stall;
    pilot_result_t want;
    @(negedge rst);
    forever begin
      stall = sink_steady ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!m_axis_tvalid);
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual value %0d state %0d chg %0b",
                   $time, m_axis_tdata[11:0], m_axis_tdata[14:12], m_axis_tuser);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata[11:0] !== want.value)
          note_mismatch("median_value", int'(want.value), int'(m_axis_tdata[11:0]));
        if (m_axis_tdata[14:12] !== want.state)
          note_mismatch("pilot_state", int'(want.state), int'(m_axis_tdata[14:12]));
        if (m_axis_tuser !== want.changed)
          note_mismatch("state_changed", int'(want.changed), int'(m_axis_tuser));
      end
    end
  end

  // Watchdog: end the run if the design hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    stim_row_t             row;
    logic [CFG_DATA_W-1:0] cfg_vals [NUM_REGS];
    int                    phase_len;
    int                    start;
    int                    random_sent;
    int                    phases;
    random_sent = 0;
    phases      = 0;

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Defaults: every tick stores and wraps, so the fifth good tick emits.
    plan_tick(12'd4095, 1'b1);
    plan_tick(12'd0,    1'b1);
    plan_tick(12'd4095, 1'b1);
    plan_tick(12'd0,    1'b1);
    plan_result(12'd4095, 12'd4095, PS_A, 1'b1);       // first emission always flags
    plan_tick(12'd0, 1'b0);                            // bad conversion on a storing tick
    plan_result(12'd0, 12'd0, PS_UNKNOWN, 1'b1);
    plan_result(12'd0, 12'd0, PS_UNKNOWN, 1'b0);       // same state, no change
    plan_tick(12'd3650, 1'b1);
    plan_tick(12'd3650, 1'b1);
    plan_tick(12'd3650, 1'b1);
    // Zero tolerance: no centre can match; upper data bits must be ignored.
    plan_write(REG_TOL, 16'hF000);
    plan_tick(12'd3650, 1'b1);
    // Widest tolerance with the highest A threshold.
    plan_write(REG_TOL,   16'h0FFF);
    plan_write(REG_A_THR, 16'hAFFF);
    plan_tick(12'd4095, 1'b1);
    // Centres at the extremes.
    plan_write(REG_B_CTR, 16'h5000);
    plan_write(REG_C_CTR, 16'h0FFF);
    plan_write(REG_E_CTR, 16'h0000);
    plan_tick(12'd0, 1'b1);
    plan_write(3'(NUM_REGS), 16'hFFFF);                // unused index
    // Back to defaults; store every third tick, emit every seventh.
    plan_write(REG_A_THR, 16'(A_THR_RST));
    plan_write(REG_B_CTR, 16'(B_CTR_RST));
    plan_write(REG_C_CTR, 16'(C_CTR_RST));
    plan_write(REG_E_CTR, 16'(E_CTR_RST));
    plan_write(REG_TOL,   16'(TOL_RST));
    plan_write(REG_DEC,   16'hFF03);
    plan_write(REG_SPU,   16'd7);
    plan_tick(12'd800, 1'b1);
    plan_tick(12'd800, 1'b0);                          // flag not looked at off decimation
    plan_tick(12'd800, 1'b0);
    plan_tick(12'd800, 1'b1);
    plan_tick(12'd800, 1'b0);
    plan_tick(12'd800, 1'b1);
    plan_tick(12'd800, 1'b1);                          // wrap emits
    // Longest update period and zero decimation (store on every tick).
    plan_write(REG_SPU, 16'hFFFF);
    plan_write(REG_DEC, 16'h0000);
    plan_tick(12'd3200, 1'b1);
    plan_tick(12'd3200, 1'b1);
    plan_tick(12'd3200, 1'b1);
    // Shrink the period below the running count: the next tick wraps.
    plan_write(REG_SPU, 16'd2);
    plan_tick(12'd3200, 1'b1);
    // Zero period: every tick wraps.
    plan_write(REG_SPU, 16'd0);
    plan_tick(12'd3300, 1'b1);
    plan_write(REG_SPU, 16'(SPU_RST));
    plan_write(REG_DEC, 16'(DEC_RST));

    // Walk the directed table; writes only with the pipeline drained.
    foreach (directed_plan[k]) begin
      if (directed_plan[k].is_write) begin
        settle();
        write_reg(directed_plan[k].index, directed_plan[k].data);
      end else begin
        send_tick(directed_plan[k]);
      end
    end

    // Random phases: fresh registers each phase, then a run of ticks.
    while (random_sent < RANDOM_TICKS) begin
      settle();
      phases++;
      case ($urandom_range(0, 9))
        0:       cfg_vals[REG_SPU] = 16'd0;
        1:       cfg_vals[REG_SPU] = 16'($urandom_range(16, 40));
        default: cfg_vals[REG_SPU] = 16'($urandom_range(1, 8));
      endcase
      case ($urandom_range(0, 9))
        0:       cfg_vals[REG_DEC] = {8'($urandom), 8'd0};
        1:       cfg_vals[REG_DEC] = {8'($urandom), 8'd255};
        2:       cfg_vals[REG_DEC] = {8'($urandom), 8'($urandom_range(4, 12))};
        default: cfg_vals[REG_DEC] = {8'($urandom), 8'($urandom_range(1, 3))};
      endcase
      case ($urandom_range(0, 7))
        0:       cfg_vals[REG_A_THR] = {4'($urandom), 12'd0};
        1:       cfg_vals[REG_A_THR] = {4'($urandom), 12'd4095};
        2, 3:    cfg_vals[REG_A_THR] = 16'($urandom);
        default: cfg_vals[REG_A_THR] = {4'($urandom), A_THR_RST};
      endcase
      if ($urandom_range(0, 1)) begin
        cfg_vals[REG_B_CTR] = {4'($urandom), B_CTR_RST};
        cfg_vals[REG_C_CTR] = {4'($urandom), C_CTR_RST};
        cfg_vals[REG_E_CTR] = {4'($urandom), E_CTR_RST};
      end else begin
        cfg_vals[REG_B_CTR] = 16'($urandom);
        cfg_vals[REG_C_CTR] = 16'($urandom);
        cfg_vals[REG_E_CTR] = 16'($urandom);
      end
      case ($urandom_range(0, 9))
        0:       cfg_vals[REG_TOL] = {4'($urandom), 12'd0};
        1:       cfg_vals[REG_TOL] = {4'($urandom), 12'd4095};
        2:       cfg_vals[REG_TOL] = 16'($urandom);
        default: cfg_vals[REG_TOL] = {4'($urandom), 12'($urandom_range(20, 300))};
      endcase
      // Rotate the write order so every register lands first now and then.
      start = $urandom_range(0, NUM_REGS - 1);
      for (int k = 0; k < NUM_REGS; k++)
        write_reg(CFG_IDX_W'((start + k) % NUM_REGS), cfg_vals[(start + k) % NUM_REGS]);

      // Hold some phases free of gaps or stalls on one or both sides.
      send_steady = ($urandom_range(0, 3) == 0);
      sink_steady = ($urandom_range(0, 3) == 0);
      phase_len   = $urandom_range(60, 180);
      if (phase_len > RANDOM_TICKS - random_sent) phase_len = RANDOM_TICKS - random_sent;
      for (int n = 0; n < phase_len; n++) begin
        row.is_write = 1'b0;
        row.index    = '0;
        row.data     = '0;
        row.sample   = pick_sample();
        row.ok       = ($urandom_range(0, 9) != 0);
        row.typed    = 1'b0;
        row.want     = '{value: '0, state: PS_UNKNOWN, changed: 1'b0};
        send_tick(row);
        random_sent++;
      end
    end

    // Drain and give the block time to show any stray result.
    settle();

    $display("Covered %0d ticks over %0d random phases and the directed table,", ticks_sent,
             phases);
    $display("checked %0d results after %0d register writes.", results_seen, writes_done);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
